FILE: hw/rtl/vrgc_pkg.sv
// ============================================================================
// vrgc_pkg: shared types, constants and a function of the voice resampler
// Holds the controller state, the command and status groups, the register
// indexes and the Q15 gain-and-clip function.
// ============================================================================
package vrgc_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int STEP_W    = 19;
    localparam int GAIN_W    = 16;
    localparam int SKIP_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 19;
    localparam int COUNT_W   = 6;

    // The step register holds Q16, so it is rescaled against this precision.
    localparam int STEP_FRAC_BITS = 16;

    localparam logic [COUNT_W-1:0] RUN_LAST_COUNT = 6'd63;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_Q16    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_Q15    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MONO_SOURCE = 2'd2;

    localparam logic [STEP_W-1:0] STEP_RESET = 19'd65536;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd32768;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GAIN,
        ST_EMIT
    } vrgc_state_t;

    typedef struct packed {
        logic capture;
        logic skip_dec;
        logic gain;
        logic step;
        logic finish;
    } vrgc_cmd_t;

    typedef struct packed {
        logic skip_pending;
        logic last;
    } vrgc_status_t;

    // Sample times Q15 gain, truncated toward zero, clipped to int16.
    function automatic logic signed [SAMPLE_W-1:0] gain_clip(
        input logic signed [SAMPLE_W-1:0] s,
        input logic [GAIN_W-1:0]          g
    );
        logic signed [GAIN_W:0]   gs;
        logic signed [32:0]       p;
        logic signed [32:0]       b;
        logic signed [17:0]       q;
        logic signed [SAMPLE_W-1:0] r;
        gs = signed'({1'b0, g});
        p  = s * gs;
        b  = p + (p[32] ? 33'sd32767 : 33'sd0);
        q  = 18'(b >>> 15);
        if (q > 18'sd32767) begin
            r = 16'sh7FFF;
        end else if (q < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = q[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/vrgc_ctrl.sv
// ============================================================================
// vrgc_ctrl: sequencing controller of the voice resampler
// Accepts a source frame, drops it or starts a run, and steps the run one
// result beat at a time.
// ============================================================================
module vrgc_ctrl import vrgc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    input  logic         s_buffer_start,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    input  vrgc_status_t status,
    output vrgc_cmd_t    cmd
);

    vrgc_state_t state_reg;
    vrgc_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_buffer_start || !status.skip_pending) begin
                        cmd.capture = 1'b1;
                        state_next  = ST_GAIN;
                    end else begin
                        cmd.skip_dec = 1'b1;
                    end
                end
            end
            ST_GAIN: begin
                cmd.gain   = 1'b1;
                cmd.step   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (status.last) begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        cmd.step = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/vrgc_dp.sv
// ============================================================================
// vrgc_dp: datapath of the voice resampler
// Phase accumulator, skip counter, run counter and the gain-and-clip stage.
// ============================================================================
module vrgc_dp import vrgc_pkg::*; #(
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  vrgc_cmd_t                  cmd,
    output vrgc_status_t               status,
    input  logic signed [SAMPLE_W-1:0] src_left,
    input  logic signed [SAMPLE_W-1:0] src_right,
    input  logic                       buffer_start,
    input  logic [STEP_W-1:0]          step_q16,
    input  logic [GAIN_W-1:0]          gain_q15,
    input  logic                       mono_source,
    output logic signed [SAMPLE_W-1:0] out_left,
    output logic signed [SAMPLE_W-1:0] out_right,
    output logic                       run_last
);

    // The accumulator stays below one frame plus one step, under 9 frames.
    localparam int ACC_W = PHASE_FRAC_BITS + SKIP_W;
    localparam int SHL   = (PHASE_FRAC_BITS >= STEP_FRAC_BITS) ?
                           PHASE_FRAC_BITS - STEP_FRAC_BITS : 0;
    localparam int SHR   = (PHASE_FRAC_BITS >= STEP_FRAC_BITS) ?
                           0 : STEP_FRAC_BITS - PHASE_FRAC_BITS;
    localparam int WIDE_W = STEP_W + SHL;
    localparam logic [ACC_W-1:0] ONE = ACC_W'(1) << PHASE_FRAC_BITS;

    logic [PHASE_FRAC_BITS-1:0]  phase_reg;
    logic [SKIP_W-1:0]           skip_reg;
    logic [ACC_W-1:0]            acc_reg;
    logic [COUNT_W-1:0]          count_reg;
    logic                        last_reg;
    logic signed [SAMPLE_W-1:0]  left_reg;
    logic signed [SAMPLE_W-1:0]  right_reg;
    logic signed [SAMPLE_W-1:0]  gl_reg;
    logic signed [SAMPLE_W-1:0]  gr_reg;

    logic [WIDE_W-1:0]           step_wide;
    logic [ACC_W-1:0]            step_scaled;
    logic [ACC_W-1:0]            acc_next;
    logic [SKIP_W-1:0]           whole;
    logic [SKIP_W-1:0]           skip_next;

    always_comb begin
        step_wide   = WIDE_W'(step_q16) << SHL;
        step_scaled = ACC_W'(step_wide >> SHR);
        acc_next    = acc_reg + step_scaled;
        whole       = acc_reg[ACC_W-1:PHASE_FRAC_BITS];
        skip_next   = (whole != '0) ? whole - SKIP_W'(1) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            skip_reg  <= '0;
        end else begin
            if (cmd.skip_dec) begin
                skip_reg <= skip_reg - SKIP_W'(1);
            end
            if (cmd.finish) begin
                phase_reg <= acc_reg[PHASE_FRAC_BITS-1:0];
                skip_reg  <= skip_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            left_reg  <= src_left;
            right_reg <= mono_source ? src_left : src_right;
            acc_reg   <= buffer_start ? '0 : ACC_W'(phase_reg);
            count_reg <= '0;
        end
        if (cmd.gain) begin
            gl_reg <= gain_clip(left_reg, gain_q15);
            gr_reg <= gain_clip(right_reg, gain_q15);
        end
        if (cmd.step) begin
            acc_reg   <= acc_next;
            count_reg <= count_reg + COUNT_W'(1);
            last_reg  <= (acc_next >= ONE) || (count_reg == RUN_LAST_COUNT);
        end
    end

    assign status.skip_pending = (skip_reg != '0);
    assign status.last         = last_reg;
    assign out_left            = gl_reg;
    assign out_right           = gr_reg;
    assign run_last            = last_reg;

endmodule

FILE: hw/rtl/voice_resample_gain_clip.sv
// ============================================================================
// voice_resample_gain_clip: nearest-sample rate converter for one voice
// Phase-accumulator resampler with Q15 gain and int16 clipping.
// ============================================================================
// Each accepted source frame is either dropped, when earlier large steps left
// frames to skip and the frame does not open a new buffer, or kept and sent
// out as a run of one to 64 identical device frames, the last of which carries
// m_run_last. A dropped frame is taken without leaving the idle state. A kept
// frame is captured, scaled in the gain state and then sent out beat by beat
// from the single result register; the accumulator steps once in the gain state
// and for each beat taken but the last; no new frame enters until the run ends.
// Configuration writes take effect at once and are meant to be made while the
// block is idle. The step register is Q16 and is rescaled to PHASE_FRAC_BITS.
// ============================================================================
module voice_resample_gain_clip import vrgc_pkg::*; #(
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DAT_W-1:0]        cfg_wdata,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [SAMPLE_W-1:0]  s_src_left,
    input  logic signed [SAMPLE_W-1:0]  s_src_right,
    input  logic                        s_buffer_start,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [SAMPLE_W-1:0]  m_out_left,
    output logic signed [SAMPLE_W-1:0]  m_out_right,
    output logic                        m_run_last
);

    // Configuration registers, all reset to their documented defaults.
    logic [STEP_W-1:0] step_q16_reg;
    logic [GAIN_W-1:0] gain_q15_reg;
    logic              mono_source_reg;

    vrgc_cmd_t    cmd;
    vrgc_status_t status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_q16_reg    <= STEP_RESET;
            gain_q15_reg    <= GAIN_RESET;
            mono_source_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_STEP_Q16:    step_q16_reg    <= cfg_wdata[STEP_W-1:0];
                REG_GAIN_Q15:    gain_q15_reg    <= cfg_wdata[GAIN_W-1:0];
                REG_MONO_SOURCE: mono_source_reg <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // The controller decides, beat by beat, what the datapath does.
    vrgc_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_buffer_start (s_buffer_start),
        .s_ready        (s_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .status         (status),
        .cmd            (cmd)
    );

    // The datapath holds the phase, the skip count and the result register.
    vrgc_dp #(
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .src_left     (s_src_left),
        .src_right    (s_src_right),
        .buffer_start (s_buffer_start),
        .step_q16     (step_q16_reg),
        .gain_q15     (gain_q15_reg),
        .mono_source  (mono_source_reg),
        .out_left     (m_out_left),
        .out_right    (m_out_right),
        .run_last     (m_run_last)
    );

    // One frame is in work at a time, so the two sides are never open together.
    a_one_side_open: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result sides open in the same cycle");

    // Taking the last beat of a run returns the block to accepting frames.
    a_last_frees_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_run_last) |=> s_ready)
        else $error("block not ready after the last beat of a run");

    // A frame that opens a buffer is always kept and never dropped.
    a_start_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_buffer_start) |=> (!s_ready && !m_valid))
        else $error("frame opening a buffer was not kept");

    // A beat that is not the last of its run is followed by another beat.
    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_run_last) |=> m_valid)
        else $error("run ended without a last beat");

endmodule

FILE: verif/tb_top.sv
// ============================================================================
// tb_top: self-checking bench for the voice resampler with gain and clipping
// Source frames go in on a valid/ready channel and device frames are checked
// against a behavioural model of the phase accumulator, skip counter and
// Q15 gain stage. Directed runs cover the edge cases, random runs the rest.
// ============================================================================
module tb_top;
    import vrgc_pkg::*;

    localparam int PHASE_BITS   = 16;
    localparam int RUN_CAP      = 64;
    // Cycles allowed for a dropped frame still in flight when the queue empties.
    localparam int SETTLE       = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SHOW_LIMIT   = 10;

    // Index with no register behind it; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       last;
    } dev_frame_t;

    logic                       aclk           = 1'b0;
    logic                       aresetn        = 1'b0;
    logic                       cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index      = '0;
    logic [CFG_DAT_W-1:0]       cfg_wdata      = '0;
    logic                       s_valid        = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_src_left     = '0;
    logic signed [SAMPLE_W-1:0] s_src_right    = '0;
    logic                       s_buffer_start = 1'b0;
    logic                       m_valid;
    logic                       m_ready        = 1'b0;
    logic signed [SAMPLE_W-1:0] m_out_left;
    logic signed [SAMPLE_W-1:0] m_out_right;
    logic                       m_run_last;

    // Shadow copy of the configuration registers and of the converter state.
    logic [STEP_W-1:0] step_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic              mono_reg;
    longint            phase_acc;
    int                skip_left;

    dev_frame_t expected_frames[$];

    // Idling percentages for the two sides, and the receiver hold-off.
    int send_idle_pct = 30;
    int recv_idle_pct = 69;
    int ready_hold    = 0;

    int fail_count     = 0;
    int cycle_count    = 0;
    int frames_kept    = 0;
    int frames_dropped = 0;
    int beats_checked  = 0;
    int capped_runs    = 0;

    voice_resample_gain_clip #(
        .PHASE_FRAC_BITS (PHASE_BITS)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_src_left     (s_src_left),
        .s_src_right    (s_src_right),
        .s_buffer_start (s_buffer_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_left     (m_out_left),
        .m_out_right    (m_out_right),
        .m_run_last     (m_run_last)
    );

    always #5 aclk = ~aclk;

    // Watchdog: a healthy run finishes far inside this many cycles.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d device frames outstanding.",
                     cycle_count, expected_frames.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // The sink either honours a hold-off, counted down here one cycle at a
    // time, or drops ready at random according to its idling percentage.
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            m_ready <= 1'b0;
            ready_hold = ready_hold - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Every result beat is matched against the oldest predicted device frame.
    // Signals are read straight after the edge, so these are pre-edge values.
    always @(posedge aclk) begin
        dev_frame_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_frames.size() == 0) begin
                fail_count++;
                if (fail_count <= SHOW_LIMIT) begin
                    $display("Unexpected beat: left %0d right %0d last %0b",
                             m_out_left, m_out_right, m_run_last);
                end
            end else begin
                want = expected_frames.pop_front();
                beats_checked++;
                if (m_out_left !== want.left || m_out_right !== want.right ||
                    m_run_last !== want.last) begin
                    fail_count++;
                    if (fail_count <= SHOW_LIMIT) begin
                        $display("Mismatch on beat %0d: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                                 beats_checked, want.left, want.right, want.last,
                                 m_out_left, m_out_right, m_run_last);
                    end
                end
            end
        end
    end

    // Sample times Q15 gain, the quotient truncated toward zero, then clipped.
    function automatic logic signed [SAMPLE_W-1:0] scale_and_clip(
        input logic signed [SAMPLE_W-1:0] s,
        input logic [GAIN_W-1:0]          g
    );
        longint p;
        longint q;
        p = longint'(s) * longint'(g);
        q = (p < 0) ? -((-p) >> 15) : (p >> 15);
        if (q > 32767) begin
            q = 32767;
        end else if (q < -32768) begin
            q = -32768;
        end
        return 16'(q);
    endfunction

    // Works out the device frames that one accepted source frame produces and
    // advances the shadow phase and skip count to match.
    task automatic resample_frame(
        input logic signed [SAMPLE_W-1:0] l,
        input logic signed [SAMPLE_W-1:0] r_in,
        input logic                       start
    );
        longint     one;
        longint     stride;
        longint     acc;
        longint     whole;
        int         n;
        bit         done;
        dev_frame_t f;
        one = longint'(1) << PHASE_BITS;
        if (start) begin
            phase_acc = 0;
            skip_left = 0;
        end else if (skip_left != 0) begin
            skip_left--;
            frames_dropped++;
            return;
        end
        frames_kept++;
        f.left  = scale_and_clip(l, gain_reg);
        f.right = scale_and_clip(mono_reg ? l : r_in, gain_reg);
        if (PHASE_BITS >= STEP_FRAC_BITS) begin
            stride = longint'(step_reg) << (PHASE_BITS - STEP_FRAC_BITS);
        end else begin
            stride = longint'(step_reg) >> (STEP_FRAC_BITS - PHASE_BITS);
        end
        acc  = phase_acc;
        n    = 0;
        done = 1'b0;
        while (!done) begin
            acc  = acc + stride;
            n++;
            done = (acc >= one) || (n >= RUN_CAP);
            f.last = done;
            expected_frames.push_back(f);
        end
        if (acc < one) begin
            capped_runs++;
        end
        whole     = acc >> PHASE_BITS;
        skip_left = (whole > 0) ? int'(whole - 1) : 0;
        if (skip_left > 15) begin
            skip_left = 15;
        end
        phase_acc = acc & (one - 1);
    endtask

    task automatic set_reg(
        input logic [CFG_IDX_W-1:0] idx,
        input logic [CFG_DAT_W-1:0] data
    );
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            REG_STEP_Q16:    step_reg = data[STEP_W-1:0];
            REG_GAIN_Q15:    gain_reg = data[GAIN_W-1:0];
            REG_MONO_SOURCE: mono_reg = data[0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Offers one source frame, possibly after a random gap, and waits for the
    // beat. Valid is left high on return so back-to-back frames stay dense.
    task automatic send_frame(
        input logic signed [SAMPLE_W-1:0] l,
        input logic signed [SAMPLE_W-1:0] r,
        input logic                       start
    );
        int gap;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_src_left     <= l;
        s_src_right    <= r;
        s_buffer_start <= start;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        resample_frame(l, r, start);
    endtask

    // Stops offering, waits for every predicted beat, then lets any dropped
    // frame still in flight clear so the block is idle for a register write.
    task automatic end_burst();
        s_valid <= 1'b0;
        while (expected_frames.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'($signed($urandom_range(0, 8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_frame();
        send_frame(random_sample(), random_sample(), $urandom_range(0, 11) == 0);
    endtask

    // Mostly larger steps keep runs short; now and then a tiny step forces
    // long capped runs. Spare upper data bits carry junk the block must mask.
    task automatic pick_random_settings();
        logic [CFG_DAT_W-1:0] step;
        logic [CFG_DAT_W-1:0] gain;
        case ($urandom_range(0, 9))
            0:       step = 19'($urandom_range(0, 1023));
            1, 2:    step = 19'($urandom_range(1024, 16383));
            3:       step = 19'h7FFFF;
            default: step = 19'($urandom_range(16384, 524287));
        endcase
        case ($urandom_range(0, 4))
            0:       gain = 19'd0;
            1:       gain = 19'd32768;
            2:       gain = 19'd65535;
            default: gain = 19'($urandom_range(0, 65535));
        endcase
        gain[CFG_DAT_W-1:GAIN_W] = 3'($urandom);
        set_reg(REG_STEP_Q16, step);
        set_reg(REG_GAIN_Q15, gain);
        set_reg(REG_MONO_SOURCE, 19'($urandom));
    endtask

    // Reset settings: unity step and gain, stereo. Sample extremes pass
    // through unchanged, one device frame each.
    task automatic test_sample_extremes();
        send_frame(16'sh7FFF, 16'sh8000, 1'b1);
        send_frame(16'sh8000, 16'sh7FFF, 1'b0);
        send_frame(16'sh0000, -16'sd1, 1'b0);
        send_frame(16'sd1, 16'sh0000, 1'b0);
        end_burst();
    endtask

    // Gain above unity clips, zero gain silences both sides while mono is set,
    // and an odd gain shows truncation toward zero on negative products.
    task automatic test_gain_and_mono();
        set_reg(REG_GAIN_Q15, 19'd65535);
        send_frame(16'sh7FFF, 16'sh8000, 1'b0);
        send_frame(16'sh8000, 16'sd16384, 1'b0);
        end_burst();
        set_reg(REG_GAIN_Q15, 19'd0);
        set_reg(REG_MONO_SOURCE, 19'd1);
        send_frame(16'sd12345, -16'sd54, 1'b0);
        end_burst();
        set_reg(REG_GAIN_Q15, 19'd16385);
        set_reg(REG_MONO_SOURCE, 19'd0);
        send_frame(-16'sd3, 16'sd3, 1'b0);
        end_burst();
    endtask

    // Steps above one drop frames; a buffer start in the middle of pending
    // skips throws them away and keeps its own frame.
    task automatic test_skip_and_start();
        set_reg(REG_GAIN_Q15, 19'd32768);
        set_reg(REG_STEP_Q16, 19'd98304);
        send_frame(16'sd100, -16'sd100, 1'b1);
        repeat (4) send_frame(random_sample(), random_sample(), 1'b0);
        end_burst();
        set_reg(REG_STEP_Q16, 19'h7FFFF);
        send_frame(16'sd7, 16'sd8, 1'b1);
        send_frame(16'sd9, 16'sd10, 1'b0);
        send_frame(16'sd11, 16'sd12, 1'b0);
        send_frame(16'sd13, 16'sd14, 1'b1);
        send_frame(16'sd15, 16'sd16, 1'b0);
        end_burst();
    endtask

    // Tiny steps: zero and sub-1024 steps from a buffer start hit the 64-beat cap, 1024 lands on
    // exactly one frame at the 64th beat. A write to the spare index follows.
    task automatic test_small_steps();
        set_reg(REG_STEP_Q16, 19'd0);
        send_frame(-16'sd2, 16'sd2, 1'b1);
        end_burst();
        set_reg(REG_STEP_Q16, 19'd1000);
        send_frame(16'sd300, 16'sd301, 1'b1);
        send_frame(16'sd302, 16'sd303, 1'b0);
        end_burst();
        set_reg(REG_STEP_Q16, 19'd1024);
        send_frame(16'sd400, -16'sd401, 1'b1);
        end_burst();
        set_reg(REG_UNUSED, 19'h5A5A5);
        send_frame(16'sd500, 16'sd501, 1'b0);
        end_burst();
    endtask

    // The sink holds off for a long stretch while frames keep coming, so the
    // block fills and must stall its input.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_reg(REG_STEP_Q16, 19'd32768);
        set_reg(REG_GAIN_Q15, 19'd32768);
        ready_hold = 300;
        repeat (24) random_frame();
        end_burst();
    endtask

    // Random settings and frames under three idling patterns in turn.
    task automatic test_random_traffic();
        int send_pct[3];
        int recv_pct[3];
        send_pct = '{30, 69, 0};
        recv_pct = '{69, 30, 0};
        for (int m = 0; m < 3; m++) begin
            send_idle_pct = send_pct[m];
            recv_idle_pct = recv_pct[m];
            for (int s = 0; s < 5; s++) begin
                pick_random_settings();
                repeat (11) random_frame();
                end_burst();
            end
        end
    endtask

    initial begin
        step_reg  = STEP_RESET;
        gain_reg  = GAIN_RESET;
        mono_reg  = 1'b0;
        phase_acc = 0;
        skip_left = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_sample_extremes();
        test_gain_and_mono();
        test_skip_and_start();
        test_small_steps();
        test_backpressure();
        test_random_traffic();

        end_burst();
        if (expected_frames.size() != 0) begin
            fail_count += expected_frames.size();
            $display("%0d device frames never arrived.", expected_frames.size());
        end
        $display("Covered %0d source frames (%0d kept, %0d dropped) and %0d device frames,",
                 frames_kept + frames_dropped, frames_kept, frames_dropped, beats_checked);
        $display("including %0d runs cut at the beat cap; %0d failures.",
                 capped_runs, fail_count);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: voice_resample_gain_clip.f
hw/rtl/vrgc_pkg.sv
hw/rtl/vrgc_ctrl.sv
hw/rtl/vrgc_dp.sv
hw/rtl/voice_resample_gain_clip.sv
verif/tb_top.sv
